// ===== rtl/htbp_pkg.sv =====
package htbp_pkg;

    localparam int SYM_W                = 8;
    localparam int CODE_W               = 32;
    localparam int LEN_W                = 6;
    localparam int BYTE_W               = 8;
    localparam int PEND_W               = 7;
    localparam int PCNT_W               = 3;
    localparam int TABLE_DEPTH          = 256;
    localparam int CFG_IDX_W            = 2;
    localparam int MAX_CODE_LEN_DEFAULT = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_END_CODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_END_LEN  = 2'd1;

    typedef enum logic [1:0] {
        ACT_LOAD   = 2'd0,
        ACT_ENCODE = 2'd1,
        ACT_FINISH = 2'd2
    } action_t;

    // item after table lookup, handed to the packer
    typedef struct packed {
        action_t             action;
        logic [CODE_W-1:0]   code;
        logic [LEN_W-1:0]    length;
    } lookup_t;

    typedef struct packed {
        logic                loading;
        logic                flushing;
        logic [PCNT_W-1:0]   pend_count;
    } pack_status_t;

endpackage

// ===== rtl/htbp_if.sv =====
interface htbp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  symbol;
    logic [31:0] code_word;
    logic [5:0]  code_length;

    modport source (output valid, output action, output symbol, output code_word,
                    output code_length, input ready);
    modport sink   (input valid, input action, input symbol, input code_word,
                    input code_length, output ready);
endinterface

interface htbp_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] packed_byte;
    logic       last_of_run;

    modport source (output valid, output packed_byte, output last_of_run, input ready);
    modport sink   (input valid, input packed_byte, input last_of_run, output ready);
endinterface

// ===== rtl/huffman_table_bit_packer.sv =====
// Channel   Dir  Payload                                       Handshake
// in_ch     in   action, symbol, code_word, code_length        valid/ready
// out_ch    out  packed_byte, last_of_run                      valid/ready
// cfg       in   cfg_index, cfg_data                           cfg_we, no wait
//
// Each input item passes through the table lookup stage and then the byte buffer,
// which sends the item's bytes (none to five) one byte per cycle while out_ch is
// ready; an item with no bytes still passes through the buffer stage.
// Reset clears the table's written flags, the leftover bits and the buffer count.
// A stall on out_ch holds the buffer; the lookup stage holds one item while the
// last byte of the previous one waits, and hands it over as that byte is taken.
module huffman_table_bit_packer #(
    parameter int MAX_CODE_LEN = htbp_pkg::MAX_CODE_LEN_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    htbp_in_if.sink                         in_ch,
    htbp_out_if.source                      out_ch,
    input  logic                            cfg_we,
    input  logic [htbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [htbp_pkg::CODE_W-1:0]     cfg_data
);
    import htbp_pkg::*;

    localparam int CapLen = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

    logic [CODE_W-1:0] end_code_reg;
    logic [LEN_W-1:0]  end_len_reg;
    logic              in_accept;
    logic              lookup_valid;
    logic              advance;
    lookup_t           lookup;
    pack_status_t      status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            end_code_reg <= '0;
            end_len_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_END_CODE: end_code_reg <= cfg_data;
                CFG_END_LEN:  end_len_reg  <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    assign in_ch.ready = !lookup_valid || advance;
    assign in_accept   = in_ch.valid && in_ch.ready;

    htbp_table #(
        .CAP_LEN (CapLen)
    ) u_table (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .action       (action_t'(in_ch.action)),
        .symbol       (in_ch.symbol),
        .code_word    (in_ch.code_word),
        .code_length  (in_ch.code_length),
        .advance      (advance),
        .lookup_valid (lookup_valid),
        .lookup       (lookup)
    );

    htbp_pack #(
        .CAP_LEN (CapLen)
    ) u_pack (
        .clk          (clk),
        .rst_n        (rst_n),
        .lookup_valid (lookup_valid),
        .lookup       (lookup),
        .end_code     (end_code_reg),
        .end_len      (end_len_reg),
        .advance      (advance),
        .out_valid    (out_ch.valid),
        .out_ready    (out_ch.ready),
        .out_byte     (out_ch.packed_byte),
        .out_last     (out_ch.last_of_run),
        .status       (status)
    );

    // a finish leaves no leftover bits
    a_finish_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (status.loading && status.flushing) |=> (status.pend_count == '0))
        else $error("leftover bits remain after finish");

    // a waiting item in the lookup stage is not dropped
    a_lookup_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (lookup_valid && !advance) |=> lookup_valid)
        else $error("lookup stage lost an item");

    // no new item enters the buffer while more than one byte is left
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.last_of_run) |-> !status.loading)
        else $error("byte buffer overwritten before drained");

endmodule

// ===== rtl/htbp_table.sv =====
module htbp_table #(
    parameter int CAP_LEN = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  htbp_pkg::action_t            action,
    input  logic [htbp_pkg::SYM_W-1:0]   symbol,
    input  logic [htbp_pkg::CODE_W-1:0]  code_word,
    input  logic [htbp_pkg::LEN_W-1:0]   code_length,
    input  logic                         advance,
    output logic                         lookup_valid,
    output htbp_pkg::lookup_t            lookup
);
    import htbp_pkg::*;

    localparam logic [LEN_W-1:0] CapLen = LEN_W'(CAP_LEN);

    logic [CODE_W-1:0]      code_store_reg   [TABLE_DEPTH];
    logic [LEN_W-1:0]       length_store_reg [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] written_reg;

    logic                   lookup_valid_reg;
    action_t                action_reg;
    logic [CODE_W-1:0]      code_reg;
    logic [LEN_W-1:0]       length_reg;
    logic                   hit_reg;
    logic [LEN_W-1:0]       load_length;
    logic                   write_en;

    assign write_en    = accept && (action == ACT_LOAD);
    assign load_length = (code_length > CapLen) ? CapLen : code_length;

    always_ff @(posedge clk)
    begin
        if (write_en)
        begin
            code_store_reg[symbol]   <= code_word;
            length_store_reg[symbol] <= load_length;
        end
        if (accept)
        begin
            code_reg   <= code_store_reg[symbol];
            length_reg <= length_store_reg[symbol];
            action_reg <= action;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg      <= '0;
            hit_reg          <= 1'b0;
            lookup_valid_reg <= 1'b0;
        end
        else
        begin
            if (write_en)
                written_reg[symbol] <= 1'b1;
            if (accept)
            begin
                hit_reg          <= written_reg[symbol];
                lookup_valid_reg <= 1'b1;
            end
            else if (advance)
                lookup_valid_reg <= 1'b0;
        end
    end

    // an entry never loaded reads as length zero
    always_comb
    begin
        lookup.action = action_reg;
        lookup.code   = code_reg;
        lookup.length = hit_reg ? length_reg : '0;
    end

    assign lookup_valid = lookup_valid_reg;

endmodule

// ===== rtl/htbp_pack.sv =====
module htbp_pack #(
    parameter int CAP_LEN = 32
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         lookup_valid,
    input  htbp_pkg::lookup_t            lookup,
    input  logic [htbp_pkg::CODE_W-1:0]  end_code,
    input  logic [htbp_pkg::LEN_W-1:0]   end_len,
    output logic                         advance,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [htbp_pkg::BYTE_W-1:0]  out_byte,
    output logic                         out_last,
    output htbp_pkg::pack_status_t       status
);
    import htbp_pkg::*;

    localparam int BUF_W     = ((CAP_LEN + PEND_W + 7) / 8) * 8;
    localparam int MAX_BYTES = BUF_W / 8;
    localparam int CNT_W     = $clog2(MAX_BYTES + 1);
    localparam int TOT_W     = $clog2(CAP_LEN + 8);
    localparam logic [LEN_W-1:0] CapLen = LEN_W'(CAP_LEN);

    logic [PEND_W-1:0]  pend_reg, pend_next;     // left aligned, zero below count
    logic [PCNT_W-1:0]  pcnt_reg, pcnt_next;
    logic [BUF_W-1:0]   buf_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic               active;
    logic               flush;
    logic [LEN_W-1:0]   len_raw;
    logic [LEN_W-1:0]   len_use;
    logic [LEN_W-1:0]   shift_amt;
    logic [CODE_W-1:0]  word;
    logic [CAP_LEN-1:0] word_l;
    logic [BUF_W-1:0]   merged;
    logic [BUF_W-1:0]   rest;
    logic [TOT_W-1:0]   total;
    logic [CNT_W-1:0]   nfull;
    logic [CNT_W-1:0]   nbytes;
    logic [2:0]         rem;
    logic               load;
    logic               take;

    always_comb
    begin
        active  = 1'b0;
        flush   = 1'b0;
        len_raw = '0;
        word    = lookup.code;
        case (lookup.action)
            ACT_ENCODE:
            begin
                active  = 1'b1;
                len_raw = lookup.length;
            end
            ACT_FINISH:
            begin
                active  = 1'b1;
                flush   = 1'b1;
                len_raw = end_len;
                word    = end_code;
            end
            default: ;
        endcase

        len_use   = (len_raw > CapLen) ? CapLen : len_raw;
        shift_amt = CapLen - len_use;
        // left align the code; the shift drops bits above the length
        word_l    = word[CAP_LEN-1:0] << shift_amt;
        merged    = {pend_reg, {(BUF_W - PEND_W){1'b0}}}
                  | ({word_l, {(BUF_W - CAP_LEN){1'b0}}} >> pcnt_reg);
        total     = TOT_W'(pcnt_reg) + TOT_W'(len_use);
        nfull     = CNT_W'(total >> 3);
        rem       = total[2:0];
        nbytes    = nfull + CNT_W'(flush && (rem != 3'd0));
        rest      = merged << {nfull, 3'b000};
        pend_next = flush ? '0 : rest[BUF_W-1 -: PEND_W];
        pcnt_next = flush ? '0 : rem;
    end

    assign take    = out_valid && out_ready;
    assign advance = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && out_ready);
    assign load    = lookup_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            pcnt_reg <= '0;
            cnt_reg  <= '0;
        end
        else if (load)
        begin
            if (active)
            begin
                pend_reg <= pend_next;
                pcnt_reg <= pcnt_next;
                cnt_reg  <= nbytes;
            end
            else
                cnt_reg  <= '0;
        end
        else if (take)
            cnt_reg <= cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= merged;
        else if (take)
            buf_reg <= buf_reg << BYTE_W;
    end

    assign out_valid = (cnt_reg != '0);
    assign out_byte  = buf_reg[BUF_W-1 -: BYTE_W];
    assign out_last  = (cnt_reg == CNT_W'(1));

    always_comb
    begin
        status.loading    = load && active;
        status.flushing   = flush;
        status.pend_count = pcnt_reg;
    end

endmodule
